@@ rtl/core/pfa_pkg.sv @@
// shared types, widths and codes for the page frame allocator
package pfa_pkg;

    // field widths
    localparam int FRAME_W  = 20;
    localparam int END_W    = 21;
    localparam int COUNT_W  = 21;
    localparam int TOTAL_W  = 32;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 21;

    // default free stack depth
    localparam int DEF_STACK_DEPTH = 1024;

    // response status codes
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OOM  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    // request kinds
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_FRAME = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_FRAME   = 2'd1;

    // request transaction
    typedef struct packed {
        logic               kind;
        logic [FRAME_W-1:0] frame_in;
    } pfa_req_t;

    // response transaction
    typedef struct packed {
        logic [FRAME_W-1:0]  frame_out;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  free_count;
        logic [TOTAL_W-1:0]  allocated_count;
    } pfa_rsp_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic commit;
    } pfa_cmd_t;

endpackage

@@ rtl/core/pfa_dpath.sv @@
// datapath: config registers, free stack memory, bump pointer and counters
module pfa_dpath #(
    parameter int STACK_DEPTH = pfa_pkg::DEF_STACK_DEPTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  pfa_pkg::pfa_cmd_t                cmd,
    input  pfa_pkg::pfa_req_t                req,
    input  logic                             cfg_valid,
    input  logic [pfa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pfa_pkg::CFG_DATA_W-1:0]   cfg_data,
    output pfa_pkg::pfa_rsp_t                rsp
);
    import pfa_pkg::*;

    localparam int FILL_W = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int POS_W  = END_W + 1;
    localparam logic [FILL_W-1:0] FILL_MAX  = FILL_W'(STACK_DEPTH);
    localparam logic [END_W-1:0]  FRAME_LIM = END_W'(1) << FRAME_W;
    localparam logic [POS_W-1:0]  COUNT_MAX = POS_W'({COUNT_W{1'b1}});

    logic [FRAME_W-1:0] stack_mem [STACK_DEPTH];

    logic [FRAME_W-1:0] start_reg;
    logic [END_W-1:0]   end_reg;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [END_W-1:0]   fresh_off_reg, fresh_off_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic               kind_reg;
    logic [FRAME_W-1:0] frame_reg;
    logic [FRAME_W-1:0] rd_data_reg;
    pfa_rsp_t           rsp_reg, rsp_next;

    logic [END_W-1:0]    usable_end;
    logic [POS_W-1:0]    pos, pos_next;
    logic [POS_W-1:0]    fresh_left;
    logic [POS_W-1:0]    count_sum;
    logic                fresh_avail;
    logic                push_en;
    logic [FRAME_W-1:0]  got;
    logic [STATUS_W-1:0] status_c;
    logic [ADDR_W-1:0]   rd_addr;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            end_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_START_FRAME: start_reg <= cfg_data[FRAME_W-1:0];
                CFG_END_FRAME:   end_reg   <= cfg_data[END_W-1:0];
                default:         ;
            endcase
        end
    end

    // request latch on accept
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg  <= req.kind;
            frame_reg <= req.frame_in;
        end
    end

    // stack top address, read on accept
    assign rd_addr = ADDR_W'(fill_reg - FILL_W'(1));

    // free stack memory, registered read
    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            stack_mem[fill_reg[ADDR_W-1:0]] <= frame_reg;
        end
        if (cmd.load)
        begin
            rd_data_reg <= stack_mem[rd_addr];
        end
    end

    // bump position and fresh frame availability
    assign usable_end  = (end_reg > FRAME_LIM) ? FRAME_LIM : end_reg;
    assign pos         = POS_W'(start_reg) + POS_W'(fresh_off_reg);
    assign fresh_avail = POS_W'(usable_end) > pos;

    // step decision
    always_comb
    begin
        fill_next      = fill_reg;
        fresh_off_next = fresh_off_reg;
        total_next     = total_reg;
        got            = '0;
        status_c       = ST_OK;
        push_en        = 1'b0;
        if (kind_reg == KIND_ALLOC)
        begin
            if (fill_reg != '0)
            begin
                fill_next  = fill_reg - FILL_W'(1);
                got        = rd_data_reg;
                total_next = total_reg + TOTAL_W'(1);
            end
            else if (fresh_avail)
            begin
                got            = pos[FRAME_W-1:0];
                fresh_off_next = fresh_off_reg + END_W'(1);
                total_next     = total_reg + TOTAL_W'(1);
            end
            else
            begin
                status_c = ST_OOM;
            end
        end
        else
        begin
            if (fill_reg < FILL_MAX)
            begin
                fill_next = fill_reg + FILL_W'(1);
                push_en   = cmd.commit;
            end
            else
            begin
                status_c = ST_FULL;
            end
        end
    end

    // free frame count after the step
    assign pos_next   = POS_W'(start_reg) + POS_W'(fresh_off_next);
    assign fresh_left = (POS_W'(usable_end) > pos_next) ? (POS_W'(usable_end) - pos_next) : '0;
    assign count_sum  = POS_W'(fill_next) + fresh_left;

    always_comb
    begin
        rsp_next.frame_out       = got;
        rsp_next.status          = status_c;
        rsp_next.free_count      = (count_sum > COUNT_MAX) ? {COUNT_W{1'b1}}
                                                           : count_sum[COUNT_W-1:0];
        rsp_next.allocated_count = total_next;
    end

    // allocator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            fresh_off_reg <= '0;
            total_reg     <= '0;
        end
        else if (cmd.commit)
        begin
            fill_reg      <= fill_next;
            fresh_off_reg <= fresh_off_next;
            total_reg     <= total_next;
        end
    end

    // response register
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp = rsp_reg;

    // stack fill never passes the depth
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_MAX)
        else $error("free stack fill beyond depth");

    // a successful allocation bumps the running total
    a_total_inc: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && (kind_reg == KIND_ALLOC) && (status_c == ST_OK)
        |=> total_reg == $past(total_reg) + TOTAL_W'(1))
        else $error("allocation count not incremented");

    // an error response leaves the stack and bump pointer alone
    a_err_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && (status_c != ST_OK)
        |=> (fill_reg == $past(fill_reg)) && (fresh_off_reg == $past(fresh_off_reg)))
        else $error("state changed on error response");

endmodule

@@ rtl/core/pfa_ctrl.sv @@
// controller: request acceptance, execute sequencing and response valid
module pfa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output pfa_pkg::pfa_cmd_t cmd
);
    import pfa_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg, state_next;
    logic rsp_valid_reg, rsp_valid_next;
    logic slot_free;

    assign req_stall = (state_reg != S_IDLE);
    assign slot_free = !rsp_valid_reg || !rsp_stall;

    // command decode
    always_comb
    begin
        cmd.load   = (state_reg == S_IDLE) && req_valid;
        cmd.commit = (state_reg == S_EXEC) && slot_free;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (cmd.commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // response valid tracking
    always_comb
    begin
        if (cmd.commit)
        begin
            rsp_valid_next = 1'b1;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg && rsp_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

    // an accepted request always moves to execute
    a_load_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == S_EXEC)
        else $error("accepted request did not enter execute");

    // a commit always presents a response next cycle
    a_commit_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> rsp_valid_reg)
        else $error("commit without response");

    // execute waits while the response slot is blocked
    a_exec_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) && !slot_free |=> state_reg == S_EXEC)
        else $error("execute left while response slot blocked");

endmodule

@@ rtl/core/page_frame_allocator_core.sv @@
// Page frame allocator: LIFO free stack with bump pointer fallback.
// A request is latched on accept and enters execute; it commits once the response slot is free.
// A new request is stalled while one is in execute; the stack top comes from a registered memory read.
// A waiting response does not block the next request, which waits in execute for the slot.
// Reset (async, active low) clears config, stack fill, bump offset and allocation count.
// The free stack memory is not cleared; only entries below the fill are ever used.
module page_frame_allocator_core #(
    parameter int STACK_DEPTH = pfa_pkg::DEF_STACK_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  pfa_pkg::pfa_req_t               req,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output pfa_pkg::pfa_rsp_t               rsp,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pfa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pfa_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import pfa_pkg::*;

    pfa_cmd_t cmd;

    // config writes always taken
    assign cfg_ready = 1'b1;

    // sequencing
    pfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd)
    );

    // allocator datapath
    pfa_dpath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .req       (req),
        .cfg_valid (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rsp       (rsp)
    );

endmodule
